[sv/cpi_pkg.sv]
`timescale 1ns / 1ps
// shared constants, widths and types for the circle pair intersection pipeline
// no dependencies

package cpi_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;
    localparam int RAD_BITS   = 15;
    localparam int OUT_BITS   = 26;
    localparam int REL_W      = 2;
    localparam int GUARD_BITS = ((FRAC_BITS + 2) < 13) ? (FRAC_BITS + 2) : 13;

    localparam int D_W     = COORD_BITS + 1;
    localparam int DD_W    = 2 * D_W;
    localparam int SUM_W   = RAD_BITS + 1;
    localparam int SQ_W    = 2 * SUM_W;
    localparam int R2_W    = 2 * RAD_BITS;
    localparam int T_W     = DD_W + 2;
    localparam int K_W     = 2 * SQ_W;
    localparam int SQRT_IT = K_W / 2 + GUARD_BITS;
    localparam int REM_W   = SQRT_IT + 2;
    localparam int P_W     = T_W + D_W;
    localparam int V_W     = D_W + SQRT_IT + 1;
    localparam int NUM_W   = (((P_W + GUARD_BITS) > V_W) ? (P_W + GUARD_BITS) : V_W) + 1;
    localparam int Q_W     = DD_W + GUARD_BITS + 1;
    localparam int QUO_W   = RAD_BITS + FRAC_BITS + 2;
    localparam int N_W     = NUM_W + FRAC_BITS + 1;
    localparam int W_W     = QUO_W + 2;
    localparam int LANES   = 4;

    typedef enum logic [REL_W-1:0] {
        REL_SAME = 2'd0,
        REL_NONE = 2'd1,
        REL_ONE  = 2'd2,
        REL_TWO  = 2'd3
    } t_rel;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] ax;
        logic signed [COORD_BITS-1:0] ay;
        logic signed [D_W-1:0]        dx;
        logic signed [D_W-1:0]        dy;
        logic signed [T_W-1:0]        t;
        logic [DD_W-1:0]              dd;
        t_rel                         rel;
        logic                         geo;
    } t_pay;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] ax;
        logic signed [COORD_BITS-1:0] ay;
        t_rel                         rel;
        logic                         geo;
    } t_fin;

endpackage

[sv/circle_pair_intersection_top.sv]
`timescale 1ns / 1ps
// circle pair intersection: classify two integer circles and give the crossing points
// depends on cpi_pkg
// throughput: one word per cycle unless stalled; the stall-free path is the 42-stage root pipeline
//   followed by the 25-stage quotient pipeline, each stage one compare and subtract
// back-pressure: the whole pipeline holds while the output register is full and stalled
// reset: synchronous active low, clears every valid bit; data registers are not reset

module circle_pair_intersection_top (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [cpi_pkg::COORD_BITS-1:0]  i_first_center_x,
    input  logic signed [cpi_pkg::COORD_BITS-1:0]  i_first_center_y,
    input  logic        [cpi_pkg::RAD_BITS-1:0]    i_first_radius,
    input  logic signed [cpi_pkg::COORD_BITS-1:0]  i_second_center_x,
    input  logic signed [cpi_pkg::COORD_BITS-1:0]  i_second_center_y,
    input  logic        [cpi_pkg::RAD_BITS-1:0]    i_second_radius,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic        [cpi_pkg::REL_W-1:0]       o_relation,
    output logic signed [cpi_pkg::OUT_BITS-1:0]    o_point_one_x,
    output logic signed [cpi_pkg::OUT_BITS-1:0]    o_point_one_y,
    output logic signed [cpi_pkg::OUT_BITS-1:0]    o_point_two_x,
    output logic signed [cpi_pkg::OUT_BITS-1:0]    o_point_two_y
);
    import cpi_pkg::*;

    // global advance: everything moves unless the output word is held
    logic en;
    logic r_o_valid;
    assign en      = !(r_o_valid && i_stall);
    assign o_stall = !en;

    // ---------------- stage a: center deltas, radius sum and difference
    logic                         r_a_vld;
    logic signed [COORD_BITS-1:0] r_a_ax, r_a_ay;
    logic signed [D_W-1:0]        r_a_dx, r_a_dy;
    logic [RAD_BITS-1:0]          r_a_ra, r_a_rb, r_a_dif;
    logic [SUM_W-1:0]             r_a_sum;
    logic signed [D_W-1:0]        n_a_dx, n_a_dy;
    logic [SUM_W-1:0]             n_a_sum;
    logic [RAD_BITS-1:0]          n_a_dif;

    always_comb begin
        n_a_dx  = D_W'(i_second_center_x) - D_W'(i_first_center_x);
        n_a_dy  = D_W'(i_second_center_y) - D_W'(i_first_center_y);
        n_a_sum = SUM_W'(i_first_radius) + SUM_W'(i_second_radius);
        if (i_first_radius > i_second_radius) begin
            n_a_dif = i_first_radius - i_second_radius;
        end else begin
            n_a_dif = i_second_radius - i_first_radius;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_ax  <= i_first_center_x;
            r_a_ay  <= i_first_center_y;
            r_a_dx  <= n_a_dx;
            r_a_dy  <= n_a_dy;
            r_a_ra  <= i_first_radius;
            r_a_rb  <= i_second_radius;
            r_a_sum <= n_a_sum;
            r_a_dif <= n_a_dif;
        end
    end

    // ---------------- stage b: all squares
    logic                         r_b_vld;
    logic signed [COORD_BITS-1:0] r_b_ax, r_b_ay;
    logic signed [D_W-1:0]        r_b_dx, r_b_dy;
    logic [DD_W-1:0]              r_b_dx2, r_b_dy2;
    logic [R2_W-1:0]              r_b_ra2, r_b_rb2, r_b_dif2;
    logic [SQ_W-1:0]              r_b_sum2;
    logic                         r_b_same;
    logic signed [DD_W-1:0]       n_b_sx, n_b_sy;
    logic [R2_W-1:0]              n_b_ra2, n_b_rb2, n_b_dif2;
    logic [SQ_W-1:0]              n_b_sum2;

    always_comb begin
        n_b_sx   = DD_W'(r_a_dx) * DD_W'(r_a_dx);
        n_b_sy   = DD_W'(r_a_dy) * DD_W'(r_a_dy);
        n_b_ra2  = R2_W'(r_a_ra) * R2_W'(r_a_ra);
        n_b_rb2  = R2_W'(r_a_rb) * R2_W'(r_a_rb);
        n_b_dif2 = R2_W'(r_a_dif) * R2_W'(r_a_dif);
        n_b_sum2 = SQ_W'(r_a_sum) * SQ_W'(r_a_sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (en) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_ax   <= r_a_ax;
            r_b_ay   <= r_a_ay;
            r_b_dx   <= r_a_dx;
            r_b_dy   <= r_a_dy;
            r_b_dx2  <= $unsigned(n_b_sx);
            r_b_dy2  <= $unsigned(n_b_sy);
            r_b_ra2  <= n_b_ra2;
            r_b_rb2  <= n_b_rb2;
            r_b_dif2 <= n_b_dif2;
            r_b_sum2 <= n_b_sum2;
            r_b_same <= (r_a_dif == '0);
        end
    end

    // ---------------- stage c: squared distance, classification, root factors
    logic                   r_c_vld;
    t_pay                   r_c_pay;
    logic [SQ_W-1:0]        r_c_a, r_c_b;
    t_pay                   n_c_pay;
    logic [DD_W-1:0]        n_c_dd;
    logic                   n_c_far, n_c_inner;

    always_comb begin
        n_c_dd     = r_b_dx2 + r_b_dy2;
        n_c_far    = n_c_dd > DD_W'(r_b_sum2);
        n_c_inner  = n_c_dd < DD_W'(r_b_dif2);
        n_c_pay.ax = r_b_ax;
        n_c_pay.ay = r_b_ay;
        n_c_pay.dx = r_b_dx;
        n_c_pay.dy = r_b_dy;
        n_c_pay.dd = n_c_dd;
        n_c_pay.t  = $signed(T_W'(r_b_ra2)) - $signed(T_W'(r_b_rb2))
                   + $signed(T_W'(n_c_dd));
        // same center: identical or nested; otherwise apart or inside means no point
        priority if (n_c_dd == '0) begin
            n_c_pay.rel = r_b_same ? REL_SAME : REL_NONE;
            n_c_pay.geo = 1'b0;
        end else if (n_c_far || n_c_inner) begin
            n_c_pay.rel = REL_NONE;
            n_c_pay.geo = 1'b0;
        end else begin
            n_c_pay.rel = REL_TWO;
            n_c_pay.geo = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (en) begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_pay <= n_c_pay;
            r_c_a   <= SQ_W'(DD_W'(r_b_sum2) - n_c_dd);
            r_c_b   <= SQ_W'(n_c_dd - DD_W'(r_b_dif2));
        end
    end

    // ---------------- stage d and root pipeline: k = a*b, then one root digit per stage
    logic                 r_sq_vld  [0:SQRT_IT];
    t_pay                 r_sq_pay  [0:SQRT_IT];
    logic [K_W-1:0]       r_sq_k    [0:SQRT_IT];
    logic [REM_W-1:0]     r_sq_rem  [0:SQRT_IT];
    logic [SQRT_IT-1:0]   r_sq_root [0:SQRT_IT];
    logic [K_W-1:0]       n_d_k;

    always_comb begin
        n_d_k = K_W'(r_c_a) * K_W'(r_c_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld[0] <= 1'b0;
        end else if (en) begin
            r_sq_vld[0] <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_pay[0]  <= r_c_pay;
            r_sq_k[0]    <= n_d_k;
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
        end
    end

    for (genvar j = 0; j < SQRT_IT; j++) begin : g_sq
        logic [1:0]         pair;
        logic [REM_W+1:0]   rem2, trial;
        logic [REM_W-1:0]   nrem;
        logic [SQRT_IT-1:0] nroot;
        t_pay               npay;

        always_comb begin
            pair  = r_sq_k[j][K_W-1 -: 2];
            rem2  = {r_sq_rem[j], pair};
            trial = (REM_W + 2)'({r_sq_root[j], 2'b01});
            npay  = r_sq_pay[j];
            // a zero radicand means the circles touch
            if (j == 0 && npay.geo) begin
                npay.rel = (r_sq_k[j] == '0) ? REL_ONE : REL_TWO;
            end
            if (rem2 >= trial) begin
                nrem  = REM_W'(rem2 - trial);
                nroot = {r_sq_root[j][SQRT_IT-2:0], 1'b1};
            end else begin
                nrem  = REM_W'(rem2);
                nroot = {r_sq_root[j][SQRT_IT-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[j+1] <= 1'b0;
            end else if (en) begin
                r_sq_vld[j+1] <= r_sq_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq_pay[j+1]  <= npay;
                r_sq_k[j+1]    <= r_sq_k[j] << 2;
                r_sq_rem[j+1]  <= nrem;
                r_sq_root[j+1] <= nroot;
            end
        end
    end

    // ---------------- stage e: products of t and root with the deltas
    logic                   r_e_vld;
    t_fin                   r_e_fin;
    logic [Q_W-1:0]         r_e_q;
    logic signed [P_W-1:0]  r_e_p, r_e_u;
    logic signed [V_W-1:0]  r_e_v, r_e_w;
    logic signed [T_W-1:0]  e_t;
    logic signed [D_W-1:0]  e_dx, e_dy;
    logic signed [SQRT_IT:0] e_s;
    logic signed [P_W-1:0]  n_e_p, n_e_u;
    logic signed [V_W-1:0]  n_e_v, n_e_w;
    t_fin                   n_e_fin;

    always_comb begin
        e_t   = r_sq_pay[SQRT_IT].t;
        e_dx  = r_sq_pay[SQRT_IT].dx;
        e_dy  = r_sq_pay[SQRT_IT].dy;
        e_s   = $signed({1'b0, r_sq_root[SQRT_IT]});
        n_e_p = P_W'(e_t) * P_W'(e_dx);
        n_e_u = P_W'(e_t) * P_W'(e_dy);
        n_e_v = V_W'(e_dy) * V_W'(e_s);
        n_e_w = V_W'(e_dx) * V_W'(e_s);
        n_e_fin.ax  = r_sq_pay[SQRT_IT].ax;
        n_e_fin.ay  = r_sq_pay[SQRT_IT].ay;
        n_e_fin.rel = r_sq_pay[SQRT_IT].rel;
        n_e_fin.geo = r_sq_pay[SQRT_IT].geo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (en) begin
            r_e_vld <= r_sq_vld[SQRT_IT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_fin <= n_e_fin;
            r_e_q   <= Q_W'(r_sq_pay[SQRT_IT].dd) << (GUARD_BITS + 1);
            r_e_p   <= n_e_p;
            r_e_u   <= n_e_u;
            r_e_v   <= n_e_v;
            r_e_w   <= n_e_w;
        end
    end

    // ---------------- stage f: the four numerators
    logic                    r_f_vld;
    t_fin                    r_f_fin;
    logic [Q_W-1:0]          r_f_q;
    logic signed [NUM_W-1:0] r_f_n [0:LANES-1];
    logic signed [NUM_W-1:0] f_pg, f_ug, f_v, f_w;

    always_comb begin
        f_pg = NUM_W'(r_e_p);
        f_ug = NUM_W'(r_e_u);
        f_v  = NUM_W'(r_e_v);
        f_w  = NUM_W'(r_e_w);
        f_pg = f_pg <<< GUARD_BITS;
        f_ug = f_ug <<< GUARD_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (en) begin
            r_f_vld <= r_e_vld;
        end
    end

    // lane order: point one x, point one y, point two x, point two y
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_fin  <= r_e_fin;
            r_f_q    <= r_e_q;
            r_f_n[0] <= f_pg + f_v;
            r_f_n[1] <= f_ug - f_w;
            r_f_n[2] <= f_pg - f_v;
            r_f_n[3] <= f_ug + f_w;
        end
    end

    // ---------------- quotient pipeline: one quotient bit per stage, four lanes
    logic               r_dv_vld [0:QUO_W];
    t_fin               r_dv_fin [0:QUO_W];
    logic [Q_W-1:0]     r_dv_q   [0:QUO_W];
    logic               r_dv_neg [0:QUO_W][0:LANES-1];
    logic [Q_W-1:0]     r_dv_rem [0:QUO_W][0:LANES-1];
    logic [QUO_W-1:0]   r_dv_quo [0:QUO_W][0:LANES-1];
    logic [QUO_W-1:0]   r_dv_low [0:QUO_W][0:LANES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld[0] <= 1'b0;
        end else if (en) begin
            r_dv_vld[0] <= r_f_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_fin[0] <= r_f_fin;
            r_dv_q[0]   <= r_f_q;
        end
    end

    // magnitude scaled by 2^(frac+1), split into starting remainder and bits to shift in
    for (genvar l = 0; l < LANES; l++) begin : g_mag
        logic             neg;
        logic [NUM_W-1:0] mag;
        logic [N_W-1:0]   nn;

        always_comb begin
            neg = r_f_n[l][NUM_W-1];
            mag = neg ? $unsigned(-r_f_n[l]) : $unsigned(r_f_n[l]);
            nn  = {mag, {(FRAC_BITS + 1){1'b0}}};
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_neg[0][l] <= neg;
                r_dv_rem[0][l] <= nn[QUO_W +: Q_W];
                r_dv_low[0][l] <= nn[QUO_W-1:0];
                r_dv_quo[0][l] <= '0;
            end
        end
    end

    for (genvar j = 0; j < QUO_W; j++) begin : g_dv
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[j+1] <= 1'b0;
            end else if (en) begin
                r_dv_vld[j+1] <= r_dv_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_fin[j+1] <= r_dv_fin[j];
                r_dv_q[j+1]   <= r_dv_q[j];
            end
        end

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [Q_W:0]   r2, qq;
            logic [Q_W-1:0] nrem;
            logic           bit_q;

            always_comb begin
                r2 = {r_dv_rem[j][l], r_dv_low[j][l][QUO_W-1]};
                qq = {1'b0, r_dv_q[j]};
                if (r2 >= qq) begin
                    nrem  = Q_W'(r2 - qq);
                    bit_q = 1'b1;
                end else begin
                    nrem  = Q_W'(r2);
                    bit_q = 1'b0;
                end
            end

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_dv_neg[j+1][l] <= r_dv_neg[j][l];
                    r_dv_rem[j+1][l] <= nrem;
                    r_dv_quo[j+1][l] <= {r_dv_quo[j][l][QUO_W-2:0], bit_q};
                    r_dv_low[j+1][l] <= r_dv_low[j][l] << 1;
                end
            end
        end
    end

    // ---------------- output stage: floor, round half up, add center, zero if no point
    logic [REL_W-1:0]           r_o_rel;
    logic signed [OUT_BITS-1:0] r_o_pt [0:LANES-1];
    logic signed [OUT_BITS-1:0] o_base [0:LANES-1];

    always_comb begin
        o_base[0] = OUT_BITS'(r_dv_fin[QUO_W].ax) <<< FRAC_BITS;
        o_base[1] = OUT_BITS'(r_dv_fin[QUO_W].ay) <<< FRAC_BITS;
        o_base[2] = o_base[0];
        o_base[3] = o_base[1];
    end

    for (genvar l = 0; l < LANES; l++) begin : g_out
        logic [W_W-1:0]        wq;
        logic signed [W_W-1:0] w, off;
        logic signed [OUT_BITS-1:0] pt;

        always_comb begin
            wq  = W_W'(r_dv_quo[QUO_W][l]) + W_W'(r_dv_rem[QUO_W][l] != '0);
            if (r_dv_neg[QUO_W][l]) begin
                w = -$signed(wq);
            end else begin
                w = $signed(W_W'(r_dv_quo[QUO_W][l]));
            end
            off = (w + W_W'(1)) >>> 1;
            pt  = r_dv_fin[QUO_W].geo ? o_base[l] + OUT_BITS'(off) : '0;
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_o_pt[l] <= pt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= r_dv_vld[QUO_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_rel <= r_dv_fin[QUO_W].rel;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_relation    = r_o_rel;
    assign o_point_one_x = r_o_pt[0];
    assign o_point_one_y = r_o_pt[1];
    assign o_point_two_x = r_o_pt[2];
    assign o_point_two_y = r_o_pt[3];

endmodule

[sv/cpi_checker.sv]
`timescale 1ns / 1ps
// port-level checks for the circle pair intersection top, bound to it below
// depends on cpi_pkg and circle_pair_intersection_top

module cpi_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_valid,
    input logic                                   o_stall,
    input logic signed [cpi_pkg::COORD_BITS-1:0]  i_first_center_x,
    input logic signed [cpi_pkg::COORD_BITS-1:0]  i_first_center_y,
    input logic        [cpi_pkg::RAD_BITS-1:0]    i_first_radius,
    input logic signed [cpi_pkg::COORD_BITS-1:0]  i_second_center_x,
    input logic signed [cpi_pkg::COORD_BITS-1:0]  i_second_center_y,
    input logic        [cpi_pkg::RAD_BITS-1:0]    i_second_radius,
    input logic                                   o_valid,
    input logic                                   i_stall,
    input logic        [cpi_pkg::REL_W-1:0]       o_relation,
    input logic signed [cpi_pkg::OUT_BITS-1:0]    o_point_one_x,
    input logic signed [cpi_pkg::OUT_BITS-1:0]    o_point_one_y,
    input logic signed [cpi_pkg::OUT_BITS-1:0]    o_point_two_x,
    input logic signed [cpi_pkg::OUT_BITS-1:0]    o_point_two_y
);
    import cpi_pkg::*;

    // a held output word keeps its relation, its point one x and its point two y
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_relation) && $stable(o_point_one_x)
            && $stable(o_point_two_y))
        else $error("held output word changed");

    // input side only stalls behind a stalled full output
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output back-pressure");

    // identical or disjoint circles carry zero points
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_relation == REL_SAME || o_relation == REL_NONE) |->
            o_point_one_x == '0 && o_point_one_y == '0
            && o_point_two_x == '0 && o_point_two_y == '0)
        else $error("points not zero without an intersection");

    // tangency repeats the single point
    a_touch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_relation == REL_ONE |->
            o_point_two_x == o_point_one_x && o_point_two_y == o_point_one_y)
        else $error("tangent points differ");

endmodule

bind circle_pair_intersection_top cpi_checker u_cpi_checker (.*);

[test/testbench.sv]
`timescale 1ns / 1ps
// self-checking testbench for circle_pair_intersection_top: random and directed circle pairs
// depends on cpi_pkg and circle_pair_intersection_top

module testbench;
    import cpi_pkg::*;

    localparam int N_RANDOM = 1650;
    localparam int GB       = GUARD_BITS;

    typedef struct {
        logic signed [COORD_BITS-1:0] ax, ay, bx, by;
        logic        [RAD_BITS-1:0]   ra, rb;
    } t_pair;

    typedef struct {
        t_rel                       rel;
        logic signed [OUT_BITS-1:0] p1x, p1y, p2x, p2y;
    } t_cross;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic o_stall, o_valid;
    logic signed [COORD_BITS-1:0] i_first_center_x = '0, i_first_center_y = '0;
    logic signed [COORD_BITS-1:0] i_second_center_x = '0, i_second_center_y = '0;
    logic        [RAD_BITS-1:0]   i_first_radius = '0, i_second_radius = '0;
    logic        [REL_W-1:0]      o_relation;
    logic signed [OUT_BITS-1:0]   o_point_one_x, o_point_one_y, o_point_two_x, o_point_two_y;

    t_pair  pending_pairs[$];
    t_cross expected_crossings[$];
    int     total_pairs = 0;
    int     sent_pairs = 0;
    int     mismatches = 0;
    int     tx_idle_pct;
    int     rx_stall_pct;

    circle_pair_intersection_top DUT (.*);

    // ---------------- predictor ----------------

    // floor(sqrt(k) * 2^GB), one result bit per step
    function automatic longint unsigned scaled_root(longint unsigned k);
        longint unsigned root, rem, pair_bits, trial;
        root = 0;
        rem = 0;
        for (int i = 32 + GB - 1; i >= 0; i--) begin
            pair_bits = (i >= GB) ? ((k >> (2 * (i - GB))) & 64'd3) : 64'd0;
            rem = (rem << 2) | pair_bits;
            trial = (root << 2) | 64'd1;
            if (rem >= trial) begin
                rem -= trial;
                root = (root << 1) | 64'd1;
            end else begin
                root = root << 1;
            end
        end
        return root;
    endfunction

    // n * 2^FRAC_BITS / q rounded half up
    function automatic longint rounded_quotient(longint n, longint unsigned q);
        longint unsigned mag, quo, rem;
        longint w;
        mag = (n < 0) ? longint'(-n) : longint'(n);
        quo = mag / q;
        rem = mag % q;
        for (int i = 0; i < FRAC_BITS + 1; i++) begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= q) begin
                rem -= q;
                quo |= 64'd1;
            end
        end
        if (n < 0)
            w = -longint'(quo + ((rem != 0) ? 64'd1 : 64'd0));
        else
            w = longint'(quo);
        w = w + 1;
        return (w >= 0) ? w / 2 : -((-w + 1) / 2);
    endfunction

    function automatic t_cross predict_crossing(t_pair p);
        t_cross c;
        longint ax, ay, dx, dy, t, s, g, f;
        longint unsigned ra, rb, dd, sum2, dif2, k, q;
        ax = longint'(p.ax);
        ay = longint'(p.ay);
        dx = longint'(p.bx) - ax;
        dy = longint'(p.by) - ay;
        ra = p.ra;
        rb = p.rb;
        dd = dx * dx + dy * dy;
        sum2 = (ra + rb) * (ra + rb);
        dif2 = (ra > rb) ? (ra - rb) * (ra - rb) : (rb - ra) * (rb - ra);
        c.p1x = '0;
        c.p1y = '0;
        c.p2x = '0;
        c.p2y = '0;
        if (dd == 0) begin
            c.rel = (ra == rb) ? REL_SAME : REL_NONE;
        end else if (dd > sum2 || dd < dif2) begin
            c.rel = REL_NONE;
        end else begin
            t = longint'(ra * ra) - longint'(rb * rb) + longint'(dd);
            k = (sum2 - dd) * (dd - dif2);
            s = longint'(scaled_root(k));
            q = dd << (GB + 1);
            g = longint'(1) << GB;
            f = longint'(1) << FRAC_BITS;
            c.rel = (k == 0) ? REL_ONE : REL_TWO;
            c.p1x = OUT_BITS'(ax * f + rounded_quotient(t * dx * g + dy * s, q));
            c.p1y = OUT_BITS'(ay * f + rounded_quotient(t * dy * g - dx * s, q));
            c.p2x = OUT_BITS'(ax * f + rounded_quotient(t * dx * g - dy * s, q));
            c.p2y = OUT_BITS'(ay * f + rounded_quotient(t * dy * g + dx * s, q));
        end
        return c;
    endfunction

    // ---------------- stimulus helpers ----------------

    task automatic add_pair(int ax, int ay, int ra, int bx, int by, int rb);
        t_pair p;
        p.ax = COORD_BITS'(ax);
        p.ay = COORD_BITS'(ay);
        p.ra = RAD_BITS'(ra);
        p.bx = COORD_BITS'(bx);
        p.by = COORD_BITS'(by);
        p.rb = RAD_BITS'(rb);
        pending_pairs.push_back(p);
        total_pairs++;
    endtask

    function automatic int clamp_radius(int r);
        return (r < 0) ? 0 : ((r > 32767) ? 32767 : r);
    endfunction

    // random pair, mostly shaped so that the circles meet or nearly meet
    task automatic add_random_pair();
        int ax, ay, dx, dy, span, radial_len, ra, rb, m, mode;
        mode = $urandom_range(0, 9);
        ax = $urandom_range(0, 65535) - 32768;
        ay = $urandom_range(0, 65535) - 32768;
        if (mode == 0) begin
            // raw noise over the full field ranges
            add_pair(ax, ay, $urandom_range(0, 32767), $urandom_range(0, 65535) - 32768,
                     $urandom_range(0, 65535) - 32768, $urandom_range(0, 32767));
        end else if (mode == 1) begin
            // tangency from a scaled 3-4-5 triangle, outer or inner
            m = $urandom_range(1, 6000);
            ra = $urandom_range(0, 5 * m);
            dx = ($urandom_range(0, 1) ? 3 : -3) * m;
            dy = ($urandom_range(0, 1) ? 4 : -4) * m;
            if ($urandom_range(0, 1))
                add_pair(ax, ay, ra, ax + dx, ay + dy, 5 * m - ra);
            else
                add_pair(ax, ay, clamp_radius(ra + 5 * m), ax + dx, ay + dy, ra);
        end else if (mode == 2) begin
            // shared center
            ra = $urandom_range(0, 32767);
            add_pair(ax, ay, ra, ax, ay, $urandom_range(0, 1) ? ra : $urandom_range(0, 32767));
        end else begin
            // crossing or near-crossing pair at a random scale
            span = 1 << $urandom_range(1, 15);
            dx = $urandom_range(0, 2 * span) - span;
            dy = $urandom_range(0, 2 * span) - span;
            radial_len = int'($sqrt(real'(dx) * real'(dx) + real'(dy) * real'(dy)));
            ra = $urandom_range(0, radial_len + 4);
            rb = radial_len - ra + $urandom_range(0, 2 * ra + 4) - 2;
            add_pair(ax, ay, clamp_radius(ra), ax + dx, ay + dy, clamp_radius(rb));
        end
    endtask

    // ---------------- clock, reset, stimulus ----------------

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        // identical circles, also the zero circles
        add_pair(100, -200, 50, 100, -200, 50);
        add_pair(0, 0, 0, 0, 0, 0);
        // same center, other radius
        add_pair(7, 7, 10, 7, 7, 11);
        // too far apart, and one inside the other
        add_pair(0, 0, 10, 100, 0, 10);
        add_pair(0, 0, 100, 5, 0, 10);
        // outer and inner tangency
        add_pair(0, 0, 3, 5, 0, 2);
        add_pair(0, 0, 5, 2, 0, 3);
        add_pair(10, 20, 4, 13, 24, 1);
        // zero circle lying on the other circle, and off it
        add_pair(0, 0, 5, 3, 4, 0);
        add_pair(3, -4, 0, 0, 0, 5);
        add_pair(0, 0, 5, 3, 3, 0);
        // plain crossings
        add_pair(0, 0, 5, 6, 0, 5);
        add_pair(-10, 4, 9, -3, -2, 7);
        add_pair(1000, -1000, 700, 1500, -500, 600);
        // field extremes
        add_pair(-32768, -32768, 32767, 32767, 32767, 32767);
        add_pair(32767, 32767, 32767, -32768, -32768, 32767);
        add_pair(-32768, 0, 32767, 32767, 0, 32767);
        add_pair(-32768, 32767, 32767, -32768, -32767, 32767);
        add_pair(0, -32768, 32767, 0, 32767, 0);
        add_pair(-1, -1, 32767, 0, 0, 32767);
        add_pair(32767, -32768, 1, 32767, -32767, 1);
        repeat (N_RANDOM) add_random_pair();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // idling phases: none, sender idle, receiver stall, both
    always_comb begin
        unique case ((sent_pairs * 4) / ((total_pairs == 0) ? 1 : total_pairs))
            0: begin
                tx_idle_pct = 0;
                rx_stall_pct = 0;
            end
            1: begin
                tx_idle_pct = 49;
                rx_stall_pct = 0;
            end
            2: begin
                tx_idle_pct = 0;
                rx_stall_pct = 49;
            end
            default: begin
                tx_idle_pct = 28;
                rx_stall_pct = 28;
            end
        endcase
    end

    // ---------------- driver ----------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(0, 99) < rx_stall_pct);
            // load a new word when the line is free or the current word was taken
            if (!i_valid || !o_stall) begin
                if (pending_pairs.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    t_pair p;
                    p = pending_pairs.pop_front();
                    expected_crossings.push_back(predict_crossing(p));
                    sent_pairs++;
                    i_first_center_x  <= p.ax;
                    i_first_center_y  <= p.ay;
                    i_first_radius    <= p.ra;
                    i_second_center_x <= p.bx;
                    i_second_center_y <= p.by;
                    i_second_radius   <= p.rb;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_crossings.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: relation %0d", o_relation);
            end else begin
                t_cross c;
                c = expected_crossings.pop_front();
                if (o_relation !== c.rel || o_point_one_x !== c.p1x
                        || o_point_one_y !== c.p1y || o_point_two_x !== c.p2x
                        || o_point_two_y !== c.p2y) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected %0d (%0d,%0d) (%0d,%0d)",
                                  " got %0d (%0d,%0d) (%0d,%0d)"},
                                 c.rel, c.p1x, c.p1y, c.p2x, c.p2y, o_relation,
                                 o_point_one_x, o_point_one_y, o_point_two_x, o_point_two_y);
                end
            end
        end
    end

    // ---------------- end of run ----------------

    initial begin
        wait (i_rst_n);
        wait (pending_pairs.size() == 0 && expected_crossings.size() == 0);
        // give a stray extra word time to show up
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && expected_crossings.size() == 0)
            $display("PASS circle_pair_intersection_top");
        else
            $display("FAIL circle_pair_intersection_top");
        $finish;
    end

    initial begin
        #20ms;
        $display("FAIL circle_pair_intersection_top");
        $finish;
    end

endmodule

[files.f]
sv/cpi_pkg.sv
sv/circle_pair_intersection_top.sv
sv/cpi_checker.sv
test/testbench.sv
